### rtl/power_law_radius_correction_defines.svh
// Assertion macros shared by the power-law radius correction block.
`ifndef POWER_LAW_RADIUS_CORRECTION_DEFINES_SVH
`define POWER_LAW_RADIUS_CORRECTION_DEFINES_SVH

// Checks a property on the rising clock edge, ignored while reset is held.
`define PLRC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks a property on the rising clock edge at every edge, reset included.
`define PLRC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/plrc_pkg.sv
package plrc_pkg;

  localparam int unsigned RADIUS_W = 24;
  localparam int unsigned VOLUME_W = 32;
  localparam int unsigned SCALE_W  = 32;
  localparam int unsigned INVEXP_W = 18;
  localparam int unsigned FACTOR_W = 16;
  localparam int unsigned LOG_W    = 21;
  localparam int unsigned EXPON_W  = 24;
  localparam int unsigned PRED_W   = 41;
  localparam int unsigned STEPS    = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE    = 2'd0,
    CFG_INVEXP   = 2'd1,
    CFG_FACTOR   = 2'd2,
    CFG_FLOOR    = 2'd3
  } cfg_reg_e;

  // Sideband that travels beside each item through the pipeline.
  typedef struct packed {
    logic                valid;
    logic                zero;
    logic [RADIUS_W-1:0] radius;
  } side_t;

  // Integer square root, used only to build constants at elaboration.
  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bits;
    x    = x_in;
    res  = '0;
    bits = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bits > x) bits = bits >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bits != 0) begin
        if (x >= res + bits) begin
          x   = x - (res + bits);
          res = (res >> 1) + bits;
        end else begin
          res = res >> 1;
        end
        bits = bits >> 2;
      end
    end
    return res;
  endfunction

  // Factors 2^(2^-i) in Q2.30, i = 1..16, entry i-1 in the low slot first.
  function automatic logic [STEPS*32-1:0] exp2_factors();
    logic [63:0]         c;
    logic [STEPS*32-1:0] tab;
    c   = 64'd1 << 31;
    tab = '0;
    for (int i = 0; i < STEPS; i++) begin
      c = isqrt64(c << 30);
      tab[i*32 +: 32] = c[31:0];
    end
    return tab;
  endfunction

  localparam logic [STEPS*32-1:0] EXP2_C = exp2_factors();

endpackage

### rtl/plrc_log2.sv
module plrc_log2 (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  plrc_pkg::side_t                     side_i,
  input  logic [plrc_pkg::VOLUME_W-1:0]       volume_i,
  input  logic [plrc_pkg::SCALE_W-1:0]        scale_i,
  output plrc_pkg::side_t                     side_o,
  output logic [plrc_pkg::LOG_W-1:0]          log_volume_o,
  output logic [plrc_pkg::LOG_W-1:0]          log_scale_o
);

  localparam int unsigned S = plrc_pkg::STEPS;

  logic [31:0]     x_in   [2];
  logic [4:0]      k_d    [2];
  logic [31:0]     m_d    [2];

  logic [31:0]     m_q    [S+1][2];
  logic [4:0]      k_q    [S+1][2];
  logic [S-1:0]    frac_q [S+1][2];
  plrc_pkg::side_t side_q [S+1];

  // A zero scale coefficient is taken as one LSB.
  assign x_in[0] = volume_i;
  assign x_in[1] = (scale_i == '0) ? 32'd1 : scale_i;

  // Normalize both operands: top set bit gives the integer part.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      k_d[l] = '0;
      for (int b = 1; b < 32; b++) begin
        if (x_in[l][b]) k_d[l] = 5'(b);
      end
      m_d[l] = x_in[l] << (5'd31 - k_d[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q[0] <= '0;
    end else if (en_i) begin
      side_q[0] <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 2; l++) begin
        m_q[0][l]    <= m_d[l];
        k_q[0][l]    <= k_d[l];
        frac_q[0][l] <= '0;
      end
    end
  end

  // One squaring of the mantissa per stage yields one fraction bit.
  for (genvar j = 1; j <= S; j++) begin : g_step
    logic [63:0] sq   [2];
    logic [31:0] m_n  [2];
    logic        bit_n[2];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        sq[l]    = 64'(m_q[j-1][l]) * 64'(m_q[j-1][l]);
        bit_n[l] = sq[l][63];
        m_n[l]   = bit_n[l] ? sq[l][63:32] : sq[l][62:31];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[j] <= '0;
      end else if (en_i) begin
        side_q[j] <= side_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < 2; l++) begin
          m_q[j][l]    <= m_n[l];
          k_q[j][l]    <= k_q[j-1][l];
          frac_q[j][l] <= {frac_q[j-1][l][S-2:0], bit_n[l]};
        end
      end
    end
  end

  assign side_o       = side_q[S];
  assign log_volume_o = {k_q[S][0], frac_q[S][0]};
  assign log_scale_o  = {k_q[S][1], frac_q[S][1]};

endmodule

### rtl/plrc_exp2.sv
module plrc_exp2 (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  plrc_pkg::side_t                     side_i,
  input  logic signed [plrc_pkg::EXPON_W-1:0] expon_i,
  output plrc_pkg::side_t                     side_o,
  output logic [plrc_pkg::PRED_W-1:0]         pred_o
);

  localparam int unsigned S = plrc_pkg::STEPS;

  logic [31:0]                         acc_q  [S+1];
  logic signed [plrc_pkg::EXPON_W-1:0] e_q    [S+1];
  plrc_pkg::side_t                     side_q [S+1];
  plrc_pkg::side_t                     out_side_q;
  logic [plrc_pkg::PRED_W-1:0]         pred_d;
  logic [plrc_pkg::PRED_W-1:0]         pred_q;

  assign acc_q[0]  = 32'd1 << 30;
  assign e_q[0]    = expon_i;
  assign side_q[0] = side_i;

  // Fraction bit 16-j selects factor 2^(2^-j); one multiply per stage.
  for (genvar j = 1; j <= S; j++) begin : g_step
    logic [63:0] prod;
    logic [31:0] acc_n;

    always_comb begin
      prod  = 64'(acc_q[j-1]) * 64'(plrc_pkg::EXP2_C[(j-1)*32 +: 32]);
      acc_n = e_q[j-1][S-j] ? prod[61:30] : acc_q[j-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[j] <= '0;
      end else if (en_i) begin
        side_q[j] <= side_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[j] <= acc_n;
        e_q[j]   <= e_q[j-1];
      end
    end
  end

  // Apply the integer part as a shift of the Q2.30 mantissa into Q.16.
  always_comb begin
    logic signed [7:0] n;
    logic signed [8:0] sh;
    logic        [8:0] nsh;
    n   = e_q[S][plrc_pkg::EXPON_W-1:S];
    sh  = {n[7], n} - 9'sd14;
    nsh = 9'(-sh);
    if (side_q[S].zero) begin
      pred_d = '0;
    end else if (n >= 8'sd24) begin
      pred_d = {1'b1, {(plrc_pkg::PRED_W-1){1'b0}}};
    end else if (sh >= 9'sd0) begin
      pred_d = plrc_pkg::PRED_W'(acc_q[S]) << sh[3:0];
    end else if (sh <= -9'sd32) begin
      pred_d = '0;
    end else begin
      pred_d = plrc_pkg::PRED_W'(acc_q[S] >> nsh[4:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_side_q <= '0;
    end else if (en_i) begin
      out_side_q <= side_q[S];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) pred_q <= pred_d;
  end

  assign side_o = out_side_q;
  assign pred_o = pred_q;

endmodule

### rtl/power_law_radius_correction.sv
// Power-law radius correction.
// Input stream s_axis carries one segment per transaction: the measured
// radius and its growth volume. Output stream m_axis returns one result per
// input: the corrected radius on tdata and the replacement flag on tuser.
// The predicted radius (volume / scale)^(1/b) is formed by a 17-stage log2
// pipeline (normalize, then one mantissa squaring per stage), one multiply
// stage for the exponent, a 17-stage exp2 pipeline (one constant multiply
// per stage, then the final shift) and two compare stages.
// One item per cycle unless the receiver stalls; every stage holds one item.
// The configuration channel writes one register per transaction and is
// always ready; write it only while no item is in flight.
// Reset clears all valid bits and loads the default registers.
// When the receiver stalls, the whole pipeline holds and s_axis_tready drops
// until the waiting result is taken; nothing is lost or repeated.
`include "power_law_radius_correction_defines.svh"

module power_law_radius_correction (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // [23:0] measured_radius, [55:24] growth_volume
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [23:0] corrected_radius
  output logic [0:0]  m_axis_tuser,  // [0] was_replaced
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [plrc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [plrc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic [plrc_pkg::SCALE_W-1:0]  scale_q;
  logic [plrc_pkg::INVEXP_W-1:0] invexp_q;
  logic [plrc_pkg::FACTOR_W-1:0] factor_q;
  logic [plrc_pkg::RADIUS_W-1:0] floor_q;

  logic            en;
  plrc_pkg::side_t in_side;
  plrc_pkg::side_t log_side;
  plrc_pkg::side_t mul_side_q;
  plrc_pkg::side_t exp_side;
  plrc_pkg::side_t cmp_side_q;
  logic [plrc_pkg::LOG_W-1:0]          log_v;
  logic [plrc_pkg::LOG_W-1:0]          log_a;
  logic signed [plrc_pkg::LOG_W:0]     diff;
  logic signed [40:0]                  eprod;
  logic signed [plrc_pkg::EXPON_W-1:0] expon_q;
  logic [plrc_pkg::PRED_W-1:0]         pred;
  logic [plrc_pkg::PRED_W-1:0]         pred_q;
  logic [56:0]                         pf_q;
  logic [39:0]                         rf_q;
  logic                                repl;
  logic [plrc_pkg::PRED_W-1:0]         sel;
  logic [23:0]                         out_data_d;
  logic [23:0]                         out_data_q;
  logic                                out_repl_q;
  logic                                out_valid_q;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= 32'd8100250;
      invexp_q <= 18'd24675;
      factor_q <= 16'd8192;
      floor_q  <= 24'd1638;
    end else if (cfg_valid_i) begin
      unique case (plrc_pkg::cfg_reg_e'(cfg_index_i))
        plrc_pkg::CFG_SCALE:  scale_q  <= cfg_data_i;
        plrc_pkg::CFG_INVEXP: invexp_q <= cfg_data_i[plrc_pkg::INVEXP_W-1:0];
        plrc_pkg::CFG_FACTOR: factor_q <= cfg_data_i[plrc_pkg::FACTOR_W-1:0];
        plrc_pkg::CFG_FLOOR:  floor_q  <= cfg_data_i[plrc_pkg::RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_side.valid  = s_axis_tvalid;
  assign in_side.zero   = (s_axis_tdata[55:24] == '0);
  assign in_side.radius = s_axis_tdata[23:0];

  plrc_log2 u_log2 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .side_i      (in_side),
    .volume_i    (s_axis_tdata[55:24]),
    .scale_i     (scale_q),
    .side_o      (log_side),
    .log_volume_o(log_v),
    .log_scale_o (log_a)
  );

  // Exponent: (log2 v - log2 a) * (1/b), floored to 16 fraction bits.
  assign diff  = $signed({1'b0, log_v}) - $signed({1'b0, log_a});
  assign eprod = 41'(diff) * $signed({23'b0, invexp_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_side_q <= '0;
    end else if (en) begin
      mul_side_q <= log_side;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) expon_q <= eprod[39:16];
  end

  plrc_exp2 u_exp2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .side_i (mul_side_q),
    .expon_i(expon_q),
    .side_o (exp_side),
    .pred_o (pred)
  );

  // Products for the tolerance test.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_side_q <= '0;
    end else if (en) begin
      cmp_side_q <= exp_side;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pred_q <= pred;
      pf_q   <= 57'(pred) * 57'(factor_q);
      rf_q   <= 40'(exp_side.radius) * 40'(factor_q);
    end
  end

  // Tolerance test and replacement with floor and saturation.
  always_comb begin
    repl = (pf_q < 57'({cmp_side_q.radius, 12'b0}))
        || (57'({pred_q, 12'b0}) > 57'(rf_q));
    sel  = (pred_q > plrc_pkg::PRED_W'(floor_q)) ? pred_q : plrc_pkg::PRED_W'(floor_q);
    if (!repl) begin
      out_data_d = cmp_side_q.radius;
    end else if (sel > plrc_pkg::PRED_W'(24'hFFFFFF)) begin
      out_data_d = 24'hFFFFFF;
    end else begin
      out_data_d = sel[23:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= cmp_side_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_data_d;
      out_repl_q <= repl;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_repl_q;

  // A replaced radius never falls below the floor.
  `PLRC_ASSERT(a_repl_floor, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata >= floor_q, "replacement below floor radius")
  // Input back-pressure only comes from a result waiting at the output.
  `PLRC_ASSERT(a_stall_source, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready, "input stalled without output stall")
  // The configuration channel never stalls.
  `PLRC_ASSERT_ALWAYS(a_cfg_ready, cfg_ready_o, "configuration channel not ready")

endmodule
